// File: rtl/core/lal_pkg.sv
// Shared package for the lux average eclipse logger: payload types, codes,
// controller/datapath command and status structs, and the build-time lux ROM.
// No dependencies.
package lal_pkg;

  // Configuration of the block
  localparam int Window     = 10;
  localparam int LogDepth   = 50;
  localparam int LuxWidth   = 24;
  localparam int RawWidth   = 12;
  localparam int RomDepth   = 1 << RawWidth;
  localparam int MeanWidth  = 31;
  localparam int CountWidth = 9;
  localparam int CfgWidth   = 24;

  localparam logic [LuxWidth-1:0] LuxMax = '1;

  // Command and result kind codes
  localparam logic CmdSample   = 1'b0;
  localparam logic CmdDump     = 1'b1;
  localparam logic KindSample  = 1'b0;
  localparam logic KindSummary = 1'b1;

  typedef struct packed {
    logic                command;
    logic [RawWidth-1:0] raw_sample;
  } lal_in_t;

  typedef struct packed {
    logic                  result_kind;
    logic [LuxWidth-1:0]   average_lux;
    logic                  eclipse_warning;
    logic [LuxWidth-1:0]   log_minimum;
    logic [LuxWidth-1:0]   log_maximum;
    logic [MeanWidth-1:0]  log_mean_hundredths;
    logic [CountWidth-1:0] log_count;
  } lal_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;     // input transfer this cycle
    logic win_upd;     // replace oldest window entry
    logic mul_go;      // total times reciprocal
    logic avg_fix;     // correct quotient, write log ring
    logic out_avg;     // load sample result
    logic scan_issue;  // read next ring entry
    logic mean_load;   // ring sum times reciprocal of the depth
    logic div_step;    // mean quotient correction, then scaling
    logic out_sum;     // load summary result
  } lal_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_dump;
    logic prefill_full;
    logic scan_last;
    logic div_last;
    logic out_free;
  } lal_sts_t;

  typedef logic [RomDepth-1:0][LuxWidth-1:0] lux_rom_t;

  // Exact lux: largest L with L^7 * (2000*raw)^10 <= (50119*(4095-raw))^10
  function automatic logic [LuxWidth-1:0] lux_of(input longint unsigned raw);
    logic [511:0]    num;
    logic [511:0]    den;
    logic [511:0]    t;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned a;
    longint unsigned b;
    a   = 64'd50119 * (longint'(RomDepth - 1) - raw);
    b   = 64'd2000 * raw;
    num = 512'd1;
    den = 512'd1;
    for (int i = 0; i < 10; i++) begin
      num = num * 512'(a);
      den = den * 512'(b);
    end
    lo = 0;
    hi = longint'(LuxMax);
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      t   = den;
      for (int k = 0; k < 7; k++) begin
        t = t * 512'(mid);
      end
      if (t <= num) begin
        lo = mid;
      end else begin
        hi = mid - 1;
      end
    end
    return LuxWidth'(lo);
  endfunction

  function automatic lux_rom_t build_lux_rom();
    lux_rom_t rom;
    for (int r = 0; r < RomDepth; r++) begin
      rom[r] = lux_of(longint'(r));
    end
    return rom;
  endfunction

endpackage

// File: rtl/core/lux_average_eclipse_logger.sv
// Top level of the lux average eclipse logger: sequencer plus datapath.
// Depends on lal_pkg, lal_ctrl and lal_datapath.
//
//   channel | ports                        | transfer when
//   --------+------------------------------+---------------------------
//   input   | in_valid, in_stall, in_data  | in_valid && !in_stall
//   result  | out_valid, out_stall, out_data | out_valid && !out_stall
//   config  | cfg_we, cfg_data             | cfg_we
//
// A sample takes the ROM read and window update during prefill, and after it
// also the reciprocal multiply and correction steps before its result is loaded.
// A dump runs the one-entry-a-cycle ring scan over all LOG_DEPTH entries and a
// two-step reciprocal divide for the mean.
// Reset is synchronous, active low; the log ring is cleared by valid bits.
// A stalled result holds in the output register; the next item is taken
// meanwhile and waits only when its own result is ready.
module lux_average_eclipse_logger import lal_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lal_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lal_out_t            out_data,
  input  logic                cfg_we,
  input  logic [CfgWidth-1:0] cfg_data
);

  lal_cmd_t cmd;
  lal_sts_t sts;

  lal_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  lal_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // An input transfer always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after input transfer");

  // Summary result is consistent
  a_summary_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KindSummary) |->
      (out_data.log_minimum <= out_data.log_maximum) &&
      (out_data.log_count == CountWidth'(LogDepth)) &&
      (out_data.average_lux == '0))
    else $error("bad summary result");

  // Sample result leaves summary fields clear
  a_sample_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.result_kind == KindSample) |->
      (out_data.log_count == '0) && (out_data.log_mean_hundredths == '0))
    else $error("sample result carries summary fields");

endmodule

// File: rtl/core/lal_ctrl.sv
// Sequencer for the lux average eclipse logger.
// Drives the datapath command struct from its status; depends on lal_pkg.
module lal_ctrl import lal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  lal_sts_t sts,
  output lal_cmd_t cmd,
  output logic     in_stall
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN,
    ST_MUL,
    ST_FIX,
    ST_OUT_AVG,
    ST_SCAN,
    ST_DRAIN,
    ST_SCALE,
    ST_DIV,
    ST_OUT_SUM
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.is_dump ? ST_SCAN : ST_WIN;
        end
      end
      ST_WIN: begin
        cmd.win_upd = 1'b1;
        state_nxt   = sts.prefill_full ? ST_MUL : ST_IDLE;
      end
      ST_MUL: begin
        cmd.mul_go = 1'b1;
        state_nxt  = ST_FIX;
      end
      ST_FIX: begin
        cmd.avg_fix = 1'b1;
        state_nxt   = ST_OUT_AVG;
      end
      ST_OUT_AVG: begin
        if (sts.out_free) begin
          cmd.out_avg = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.mean_load = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_OUT_SUM;
        end
      end
      ST_OUT_SUM: begin
        if (sts.out_free) begin
          cmd.out_sum = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// File: rtl/core/lal_datapath.sv
// Datapath of the lux average eclipse logger: lux ROM, boxcar window,
// reciprocal divide, log ring, dump scan, reciprocal mean, output register.
// Depends on lal_pkg.
module lal_datapath import lal_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  lal_in_t             in_data,
  input  logic                cfg_we,
  input  logic [CfgWidth-1:0] cfg_data,
  input  logic                out_stall,
  input  lal_cmd_t            cmd,
  output lal_sts_t            sts,
  output logic                out_valid,
  output lal_out_t            out_data
);

  localparam lux_rom_t LuxRom = build_lux_rom();

  localparam int     WinPosW    = (Window > 1) ? $clog2(Window) : 1;
  localparam int     PreW       = $clog2(Window + 1);
  localparam longint TotMax     = longint'(Window) * longint'(LuxMax);
  localparam int     TotW       = $clog2(TotMax + 1);
  localparam int     RecipShift = TotW + 2;
  localparam int     ProdW      = TotW + RecipShift;
  localparam logic [RecipShift-1:0] WinRecip =
    RecipShift'(((longint'(1) << RecipShift) - 1) / Window);
  localparam int     LogPosW    = (LogDepth > 1) ? $clog2(LogDepth) : 1;
  localparam int     SumW       = $clog2(longint'(LogDepth) * longint'(LuxMax) + 1);
  localparam int     MeanScale  = 100;
  localparam int     FracW      = $clog2(MeanScale);
  localparam int     MeanShift  = SumW + 2;
  localparam int     MProdW     = SumW + MeanShift;
  localparam logic [MeanShift-1:0] LogRecip =
    MeanShift'(((longint'(1) << MeanShift) - 1) / LogDepth);
  localparam logic [CfgWidth-1:0] ThrReset = CfgWidth'(200);

  typedef logic [LogDepth-1:0][FracW-1:0] frac_tab_t;

  // Hundredths of a remainder over the ring depth
  function automatic frac_tab_t build_frac_tab();
    frac_tab_t tab;
    for (int r = 0; r < LogDepth; r++) begin
      tab[r] = FracW'((r * MeanScale) / LogDepth);
    end
    return tab;
  endfunction

  localparam frac_tab_t FracTab = build_frac_tab();

  // Threshold register
  logic [CfgWidth-1:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= ThrReset;
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  // Lux ROM, read on input transfer
  logic [LuxWidth-1:0] lux_r;
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      lux_r <= LuxRom[in_data.raw_sample];
    end
  end

  // Boxcar window
  logic [LuxWidth-1:0] win_r [Window];
  logic [TotW-1:0]     total_r;
  logic [TotW-1:0]     total_nxt;
  logic [WinPosW-1:0]  wpos_r;
  logic [WinPosW-1:0]  wpos_nxt;
  logic [PreW-1:0]     pre_r;
  logic                pre_full;

  assign pre_full  = (pre_r == PreW'(Window));
  assign total_nxt = total_r - TotW'(win_r[wpos_r]) + TotW'(lux_r);
  assign wpos_nxt  = (wpos_r == WinPosW'(Window - 1)) ? '0 : wpos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Window; i++) begin
        win_r[i] <= '0;
      end
      total_r <= '0;
      wpos_r  <= '0;
      pre_r   <= '0;
    end else if (cmd.win_upd) begin
      win_r[wpos_r] <= lux_r;
      total_r       <= total_nxt;
      wpos_r        <= wpos_nxt;
      if (!pre_full) begin
        pre_r <= pre_r + 1'b1;
      end
    end
  end

  // Average: multiply by reciprocal, then one correction step
  logic [ProdW-1:0]    prod_r;
  logic [TotW-1:0]     q_est;
  logic [TotW-1:0]     q_rem;
  logic [TotW-1:0]     q_fix;
  logic [LuxWidth-1:0] avg_nxt;
  logic [LuxWidth-1:0] avg_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= ProdW'(total_r) * ProdW'(WinRecip);
    end
  end

  assign q_est   = prod_r[ProdW-1:RecipShift];
  assign q_rem   = total_r - q_est * TotW'(Window);
  assign q_fix   = (q_rem >= TotW'(Window)) ? q_est + 1'b1 : q_est;
  assign avg_nxt = LuxWidth'(q_fix);

  always_ff @(posedge clk) begin
    if (cmd.avg_fix) begin
      avg_r <= avg_nxt;
    end
  end

  // Log ring with per-entry valid bits
  logic [LuxWidth-1:0] ring_mem [LogDepth];
  logic [LogDepth-1:0] ring_live_r;
  logic [LogPosW-1:0]  lpos_r;
  logic [LogPosW-1:0]  scan_r;
  logic [LuxWidth-1:0] rd_data_r;
  logic                rd_live_r;

  always_ff @(posedge clk) begin
    if (cmd.avg_fix) begin
      ring_mem[lpos_r] <= avg_nxt;
    end
    rd_data_r <= ring_mem[scan_r];
    rd_live_r <= ring_live_r[scan_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_live_r <= '0;
      lpos_r      <= '0;
    end else if (cmd.avg_fix) begin
      ring_live_r[lpos_r] <= 1'b1;
      lpos_r <= (lpos_r == LogPosW'(LogDepth - 1)) ? '0 : lpos_r + 1'b1;
    end
  end

  // Dump scan: min, max and sum, one entry a cycle
  logic                acc_go_r;
  logic [LuxWidth-1:0] acc_v;
  logic [LuxWidth-1:0] mn_r;
  logic [LuxWidth-1:0] mx_r;
  logic [SumW-1:0]     sum_r;

  assign acc_v = rd_live_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_go_r <= 1'b0;
    end else begin
      acc_go_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      scan_r <= '0;
      mn_r   <= LuxMax;
      mx_r   <= '0;
      sum_r  <= '0;
    end else begin
      if (cmd.scan_issue) begin
        scan_r <= scan_r + 1'b1;
      end
      if (acc_go_r) begin
        if (acc_v < mn_r) begin
          mn_r <= acc_v;
        end
        if (acc_v > mx_r) begin
          mx_r <= acc_v;
        end
        sum_r <= sum_r + SumW'(acc_v);
      end
    end
  end

  // Mean: sum over depth by reciprocal and correction, then quotient times
  // 100 plus the remainder's hundredths from the table
  logic [MProdW-1:0]    mprod_r;
  logic [SumW-1:0]      mq_est;
  logic [SumW-1:0]      mq_rem;
  logic                 mq_up;
  logic [LuxWidth-1:0]  mq_r;
  logic [LogPosW-1:0]   mr_r;
  logic [MeanWidth-1:0] mean_r;
  logic                 mstep_r;

  assign mq_est = mprod_r[MProdW-1:MeanShift];
  assign mq_rem = sum_r - mq_est * SumW'(LogDepth);
  assign mq_up  = (mq_rem >= SumW'(LogDepth));

  always_ff @(posedge clk) begin
    if (cmd.mean_load) begin
      mprod_r <= MProdW'(sum_r) * MProdW'(LogRecip);
      mstep_r <= 1'b0;
    end else if (cmd.div_step) begin
      if (!mstep_r) begin
        mq_r <= mq_up ? LuxWidth'(mq_est + 1'b1) : LuxWidth'(mq_est);
        mr_r <= mq_up ? LogPosW'(mq_rem - SumW'(LogDepth)) : LogPosW'(mq_rem);
      end else begin
        mean_r <= MeanWidth'(mq_r) * MeanWidth'(MeanScale) + MeanWidth'(FracTab[mr_r]);
      end
      mstep_r <= 1'b1;
    end
  end

  // Output register
  lal_out_t out_nxt;
  lal_out_t out_data_r;
  logic     out_valid_r;

  always_comb begin
    out_nxt = '0;
    if (cmd.out_sum) begin
      out_nxt.result_kind         = KindSummary;
      out_nxt.log_minimum         = mn_r;
      out_nxt.log_maximum         = mx_r;
      out_nxt.log_mean_hundredths = mean_r;
      out_nxt.log_count           = CountWidth'(LogDepth);
    end else begin
      out_nxt.result_kind     = KindSample;
      out_nxt.average_lux     = avg_r;
      out_nxt.eclipse_warning = (CfgWidth'(avg_r) < thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_avg || cmd.out_sum) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_avg || cmd.out_sum) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Status back to the sequencer
  always_comb begin
    sts              = '0;
    sts.is_dump      = (in_data.command == CmdDump);
    sts.prefill_full = pre_full;
    sts.scan_last    = (scan_r == LogPosW'(LogDepth - 1));
    sts.div_last     = mstep_r;
    sts.out_free     = !out_valid_r || !out_stall;
  end

endmodule

// File: sim/tb_top.sv
// Testbench for the lux average eclipse logger: paced samples and dump requests
// under output back-pressure, each reading predicted and checked field by field.
// Depends on lal_pkg and lux_average_eclipse_logger.
module tb_top;
  import lal_pkg::*;

  localparam int WatchdogLimit    = 4000;
  localparam int DrainLimit       = 2000;
  localparam int HoldCycles       = 300;
  localparam int ThresholdAtReset = 200;
  localparam int PhaseItems       = 370;

  typedef enum int {FlowFree, FlowLight, FlowHeavy} flow_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  lal_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  lal_out_t            out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgWidth-1:0] cfg_data  = '0;

  // Predicted state of the logger
  logic [LuxWidth-1:0] win_lux [Window];
  longint unsigned     win_sum;
  int                  win_slot;
  int                  fill_count;
  logic [LuxWidth-1:0] ring_lux [LogDepth];
  int                  ring_slot;
  logic [CfgWidth-1:0] eclipse_level;
  lal_out_t            pending_readings [$];

  int    error_count   = 0;
  int    burst_left    = 0;
  bit    pacing_on     = 1'b1;
  int    hold_requests = 0;
  int    holds_taken   = 0;
  int    hold_left     = 0;
  flow_t flow_mode     = FlowFree;
  int    flow_left     = 0;
  int    quiet_cycles  = 0;

  lux_average_eclipse_logger DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Does cand^7 * lit_pow stay within dark_pow
  function automatic bit lux_fits(input longint unsigned cand, input logic [511:0] dark_pow,
                                  input logic [511:0] lit_pow);
    logic [511:0] acc;
    int           k;
    acc = lit_pow;
    for (k = 0; k < 7; k++) begin
      acc = acc * 512'(cand);
    end
    return acc <= dark_pow;
  endfunction

  // Exact lux: float estimate of the power law, then nudged onto the integer bound
  function automatic logic [LuxWidth-1:0] raw_to_lux(input logic [RawWidth-1:0] raw);
    logic [511:0]    dark_pow;
    logic [511:0]    lit_pow;
    longint unsigned dark;
    longint unsigned lit;
    longint unsigned est;
    real             guess;
    int              i;
    if (raw == '0) begin
      return LuxMax;
    end
    dark     = 64'd50119 * (longint'(RomDepth - 1) - longint'(raw));
    lit      = 64'd2000 * longint'(raw);
    dark_pow = 512'd1;
    lit_pow  = 512'd1;
    for (i = 0; i < 10; i++) begin
      dark_pow = dark_pow * 512'(dark);
      lit_pow  = lit_pow * 512'(lit);
    end
    guess = (real'(dark) / real'(lit)) ** (10.0 / 7.0);
    if (guess >= real'(LuxMax)) begin
      est = 64'(LuxMax);
    end else begin
      est = $rtoi(guess);
    end
    while (est < 64'(LuxMax) && lux_fits(est + 1, dark_pow, lit_pow)) est++;
    while (est > 0 && !lux_fits(est, dark_pow, lit_pow)) est--;
    return est[LuxWidth-1:0];
  endfunction

  task automatic clear_model();
    int i;
    for (i = 0; i < Window; i++) win_lux[i] = '0;
    for (i = 0; i < LogDepth; i++) ring_lux[i] = '0;
    win_sum       = 0;
    win_slot      = 0;
    fill_count    = 0;
    ring_slot     = 0;
    eclipse_level = CfgWidth'(ThresholdAtReset);
  endtask

  // Apply one accepted item to the window and ring model, queue its reading if any
  task automatic average_and_log(input lal_in_t item);
    lal_out_t            reading;
    logic [LuxWidth-1:0] lux;
    logic [LuxWidth-1:0] avg;
    logic [LuxWidth-1:0] lo_lux;
    logic [LuxWidth-1:0] hi_lux;
    longint unsigned     ring_sum;
    int                  i;
    reading = '0;
    if (item.command == CmdSample) begin
      lux               = raw_to_lux(item.raw_sample);
      win_sum           = win_sum - 64'(win_lux[win_slot]) + 64'(lux);
      win_lux[win_slot] = lux;
      win_slot          = (win_slot + 1 == Window) ? 0 : win_slot + 1;
      if (fill_count < Window) begin
        fill_count++;
      end else begin
        avg                     = LuxWidth'(win_sum / Window);
        ring_lux[ring_slot]     = avg;
        ring_slot               = (ring_slot + 1 == LogDepth) ? 0 : ring_slot + 1;
        reading.result_kind     = KindSample;
        reading.average_lux     = avg;
        reading.eclipse_warning = (avg < eclipse_level);
        pending_readings.push_back(reading);
      end
    end else begin
      // min starts from the largest lux; cleared entries count as zero
      lo_lux   = LuxMax;
      hi_lux   = '0;
      ring_sum = 0;
      for (i = 0; i < LogDepth; i++) begin
        if (ring_lux[i] < lo_lux) lo_lux = ring_lux[i];
        if (ring_lux[i] > hi_lux) hi_lux = ring_lux[i];
        ring_sum += 64'(ring_lux[i]);
      end
      reading.result_kind         = KindSummary;
      reading.log_minimum         = lo_lux;
      reading.log_maximum         = hi_lux;
      reading.log_mean_hundredths = MeanWidth'(ring_sum * 100 / LogDepth);
      reading.log_count           = CountWidth'(LogDepth);
      pending_readings.push_back(reading);
    end
  endtask

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) log_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // Offer one item, with random gaps between bursts, until the transfer happens
  task automatic send_item(input lal_in_t item);
    int gap;
    gap = 0;
    if (pacing_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    average_and_log(item);
  endtask

  function automatic lal_in_t make_item(input logic cmd, input logic [RawWidth-1:0] raw);
    lal_in_t item;
    item.command    = cmd;
    item.raw_sample = raw;
    return item;
  endfunction

  // Drop valid and wait for every outstanding reading, then a tail
  task automatic settle(input int tail);
    int waited;
    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_readings.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (tail) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CfgWidth-1:0] value);
    settle(12);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we        <= 1'b0;
    eclipse_level = value;
  endtask

  // Raw values across the full scale, in the working range and near both rails; some dumps
  function automatic lal_in_t random_reading();
    lal_in_t item;
    int      band;
    band         = $urandom_range(0, 99);
    item.command = ($urandom_range(0, 99) < 4) ? CmdDump : CmdSample;
    if (band < 40) begin
      item.raw_sample = RawWidth'($urandom_range(0, RomDepth - 1));
    end else if (band < 75) begin
      item.raw_sample = RawWidth'($urandom_range(1000, 2800));
    end else if (band < 88) begin
      item.raw_sample = RawWidth'($urandom_range(RomDepth - 200, RomDepth - 1));
    end else begin
      item.raw_sample = RawWidth'($urandom_range(0, 200));
    end
    return item;
  endfunction

  // Dump straight after reset: every ring entry still cleared
  task automatic test_dump_on_empty_ring();
    send_item(make_item(CmdDump, '1));
  endtask

  // Fill the window with no readings out; a dump mid-fill sees an empty ring
  task automatic test_window_prefill();
    logic [RawWidth-1:0] raws [10];
    int                  i;
    raws = '{12'd0, 12'd4095, 12'hAAA, 12'h555, 12'd1, 12'd4094, 12'h800, 12'h7FF,
             12'd2000, 12'd3000};
    for (i = 0; i < 10; i++) begin
      send_item(make_item(CmdSample, raws[i]));
      if (i == 4) send_item(make_item(CmdDump, '0));
    end
  endtask

  // Raw zero (brightest) throughout: average climbs to the saturated maximum
  task automatic test_saturated_window();
    int i;
    for (i = 0; i < Window; i++) send_item(make_item(CmdSample, '0));
    send_item(make_item(CmdDump, 12'h5A5));
  endtask

  // Threshold at both ends: full scale average is not below full scale
  task automatic test_threshold_extremes();
    write_threshold(LuxMax);
    send_item(make_item(CmdSample, '0));
    send_item(make_item(CmdSample, '1));
    write_threshold('0);
    send_item(make_item(CmdSample, '1));
    send_item(make_item(CmdDump, '0));
    write_threshold(CfgWidth'(ThresholdAtReset));
  endtask

  // Long receiver hold-off while items keep coming, so the input stalls
  task automatic test_backpressure_fill();
    int i;
    hold_requests++;
    pacing_on = 1'b0;
    for (i = 0; i < 40; i++) begin
      if (i == 20) send_item(make_item(CmdDump, '0));
      else send_item(make_item(CmdSample, RawWidth'($urandom_range(0, RomDepth - 1))));
    end
    pacing_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    int                  phase;
    int                  n;
    logic [CfgWidth-1:0] level;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: level = CfgWidth'($urandom_range(50, 400));
        1: level = CfgWidth'($urandom_range(0, LuxMax));
        2: level = CfgWidth'($urandom_range(0, 3000));
        default: level = CfgWidth'(ThresholdAtReset);
      endcase
      write_threshold(level);
      for (n = 0; n < PhaseItems; n++) send_item(random_reading());
    end
  endtask

  // Receiver stall pattern, with a counted hold-off on request
  always @(negedge clk) begin
    if (holds_taken != hold_requests) begin
      holds_taken = hold_requests;
      hold_left   = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (flow_left == 0) begin
        flow_mode = flow_t'($urandom_range(0, 2));
        flow_left = $urandom_range(4, 64);
      end else begin
        flow_left--;
      end
      case (flow_mode)
        FlowFree:  out_stall <= 1'b0;
        FlowLight: out_stall <= ($urandom_range(0, 3) == 0);
        default:   out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Compare each result transfer with the oldest queued reading
  always @(posedge clk) begin : check_readings
    lal_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        log_mismatch("result with no reading outstanding");
      end else begin
        want = pending_readings.pop_front();
        check_field("result_kind", 64'(out_data.result_kind), 64'(want.result_kind));
        check_field("average_lux", 64'(out_data.average_lux), 64'(want.average_lux));
        check_field("eclipse_warning", 64'(out_data.eclipse_warning),
                    64'(want.eclipse_warning));
        check_field("log_minimum", 64'(out_data.log_minimum), 64'(want.log_minimum));
        check_field("log_maximum", 64'(out_data.log_maximum), 64'(want.log_maximum));
        check_field("log_mean_hundredths", 64'(out_data.log_mean_hundredths),
                    64'(want.log_mean_hundredths));
        check_field("log_count", 64'(out_data.log_count), 64'(want.log_count));
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clear_model();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_dump_on_empty_ring();
    test_window_prefill();
    test_saturated_window();
    test_threshold_extremes();
    test_backpressure_fill();
    test_random_traffic();
    settle(100);
    if (pending_readings.size() != 0) begin
      log_mismatch($sformatf("%0d readings never arrived", pending_readings.size()));
    end
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/lal_pkg.sv
rtl/core/lal_ctrl.sv
rtl/core/lal_datapath.sv
rtl/core/lux_average_eclipse_logger.sv
sim/tb_top.sv
